// ===== rtl/core/echo_median_filter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Echo median filter assertion macros
// Implication checks used by the core; they compile to nothing under ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ECHO_MEDIAN_FILTER_CORE_MACROS_SVH
`define ECHO_MEDIAN_FILTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define EMF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("echo median filter: same-cycle check failed");
`define EMF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("echo median filter: next-cycle check failed");
`else
`define EMF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EMF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/emf_pkg.sv =====
// ----------------------------------------------------------------------------
// Echo median filter package
// Shared constants, the control state type and the insert control bundle.
// ----------------------------------------------------------------------------
package emf_pkg;

    localparam int MAX_SAMPLES_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 16;

    // Width of the sample count register and of all round counters.
    localparam int CNT_W = 5;

    localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = CNT_W'(5);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             ins_en;
        logic [CNT_W-1:0] count;
    } t_ins_ctrl;

endpackage

// ===== rtl/core/emf_cell.sv =====
// ----------------------------------------------------------------------------
// Echo median filter sort cell
// One slot of the descending store: keeps its value, takes the new one,
// or takes its upper neighbor's value as the new one is inserted above it.
// ----------------------------------------------------------------------------
module emf_cell
    import emf_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_ins_en,
    input  logic                  i_occupied,
    input  logic [TIME_WIDTH-1:0] i_value,
    input  logic [TIME_WIDTH-1:0] i_prev_data,
    input  logic                  i_prev_keep,
    output logic [TIME_WIDTH-1:0] o_data,
    output logic                  o_keep
);

    logic [TIME_WIDTH-1:0] r_data;
    logic [TIME_WIDTH-1:0] n_data;

    // Equal values stay ahead of the newcomer.
    assign o_keep = i_occupied && (r_data >= i_value);
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ins_en && !o_keep) begin
            n_data = i_prev_keep ? i_value : i_prev_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// ===== rtl/core/emf_chain.sv =====
// ----------------------------------------------------------------------------
// Echo median filter cell chain
// Row of sort cells that holds the round's echoes in descending order,
// with a read port for the median slot.
// ----------------------------------------------------------------------------
module emf_chain
    import emf_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
    input  logic                  i_clk,
    input  t_ins_ctrl             i_ins,
    input  logic [TIME_WIDTH-1:0] i_value,
    input  logic [IDX_W-1:0]      i_rd_idx,
    output logic [TIME_WIDTH-1:0] o_rd_data
);

    logic [TIME_WIDTH-1:0] w_data [MAX_SAMPLES];
    logic                  w_keep [MAX_SAMPLES];

    for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
        logic                  w_occ;
        logic [TIME_WIDTH-1:0] w_prev_data;
        logic                  w_prev_keep;

        assign w_occ = (32'(i_ins.count) > 32'(g));

        if (g == 0) begin : g_head
            // The head cell has nothing above it, so it takes the new value.
            assign w_prev_data = i_value;
            assign w_prev_keep = 1'b1;
        end else begin : g_body
            assign w_prev_data = w_data[g-1];
            assign w_prev_keep = w_keep[g-1];
        end

        emf_cell #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ins_en    (i_ins.ins_en),
            .i_occupied  (w_occ),
            .i_value     (i_value),
            .i_prev_data (w_prev_data),
            .i_prev_keep (w_prev_keep),
            .o_data      (w_data[g]),
            .o_keep      (w_keep[g])
        );
    end

    assign o_rd_data = w_data[i_rd_idx];

endmodule

// ===== rtl/core/echo_median_filter_core.sv =====
// ----------------------------------------------------------------------------
// Echo median filter core: median of sample_count echo times per round.
// An item is inserted through the cell chain in the cycle it is accepted, so
// items inside a round go at 1 per cycle; after a round's last item the core
// moves to S_EMIT, which reads the median slot into the output register and
// takes no input; a result still waiting on the output stalls input there.
// Synchronous active-low reset: no round open, sample_count = 5, no output.
// ----------------------------------------------------------------------------
`include "echo_median_filter_core_macros.svh"

module echo_median_filter_core
    import emf_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CNT_W-1:0]      i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [TIME_WIDTH-1:0] i_echo_time,
    input  logic                  i_no_echo,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [TIME_WIDTH-1:0] o_median_time,
    output logic                  o_found,
    output logic [CNT_W-1:0]      o_used_count
);

    localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    t_state                r_state,        n_state;
    logic                  r_in_round,     n_in_round;
    logic [CNT_W-1:0]      r_acc,          n_acc;
    logic [CNT_W-1:0]      r_target,       n_target;
    logic [CNT_W-1:0]      r_sample_count, n_sample_count;
    logic                  r_emit_found,   n_emit_found;
    logic [IDX_W-1:0]      r_emit_idx,     n_emit_idx;
    logic [CNT_W-1:0]      r_emit_used,    n_emit_used;
    logic                  r_out_valid,    n_out_valid;
    logic [TIME_WIDTH-1:0] r_median,       n_median;
    logic                  r_found,        n_found;
    logic [CNT_W-1:0]      r_used,         n_used;

    logic                  w_in_acc;
    logic [CNT_W-1:0]      w_tgt_start;
    logic [CNT_W-1:0]      w_tgt0;
    logic [CNT_W-1:0]      w_acc0;
    logic [CNT_W-1:0]      w_tgt1;
    logic [CNT_W-1:0]      w_acc1;
    logic                  w_insert;
    logic                  w_done_none;
    logic                  w_done_med;
    t_ins_ctrl             w_ins;
    logic [TIME_WIDTH-1:0] w_rd_data;

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == S_IDLE);
    assign w_in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_median_time = r_median;
    assign o_found       = r_found;
    assign o_used_count  = r_used;

    // Round bookkeeping for the item on the input port.
    always_comb begin
        priority if (r_sample_count == '0) begin
            w_tgt_start = CNT_W'(1);
        end else if (32'(r_sample_count) > MAX_SAMPLES) begin
            w_tgt_start = CNT_W'(MAX_SAMPLES);
        end else begin
            w_tgt_start = r_sample_count;
        end
        w_tgt0      = r_in_round ? r_target : w_tgt_start;
        w_acc0      = r_in_round ? r_acc : '0;
        w_insert    = !i_no_echo && (w_acc0 < w_tgt0);
        w_tgt1      = (i_no_echo && (w_tgt0 != '0)) ? (w_tgt0 - CNT_W'(1)) : w_tgt0;
        w_acc1      = w_insert ? (w_acc0 + CNT_W'(1)) : w_acc0;
        w_done_none = (w_tgt1 == '0);
        w_done_med  = !w_done_none && (w_acc1 >= w_tgt1);
        w_ins       = '{ins_en: w_in_acc && w_insert, count: w_acc0};
    end

    emf_chain #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .TIME_WIDTH  (TIME_WIDTH),
        .IDX_W       (IDX_W)
    ) u_chain (
        .i_clk     (i_clk),
        .i_ins     (w_ins),
        .i_value   (i_echo_time),
        .i_rd_idx  (r_emit_idx),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state        = r_state;
        n_in_round     = r_in_round;
        n_acc          = r_acc;
        n_target       = r_target;
        n_sample_count = r_sample_count;
        n_emit_found   = r_emit_found;
        n_emit_idx     = r_emit_idx;
        n_emit_used    = r_emit_used;
        n_out_valid    = r_out_valid;
        n_median       = r_median;
        n_found        = r_found;
        n_used         = r_used;

        if (i_cfg_valid) begin
            n_sample_count = i_cfg_data;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_in_round = 1'b1;
                    n_acc      = w_acc1;
                    n_target   = w_tgt1;
                    if (w_done_none || w_done_med) begin
                        n_state      = S_EMIT;
                        n_in_round   = 1'b0;
                        n_acc        = '0;
                        n_emit_found = w_done_med;
                        n_emit_idx   = IDX_W'(w_tgt1 >> 1);
                        n_emit_used  = w_done_med ? w_acc1 : '0;
                    end
                end
            end
            S_EMIT: begin
                // The chain is frozen here, so the median slot is stable.
                if (!r_out_valid || i_out_ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_median    = r_emit_found ? w_rd_data : '0;
                    n_found     = r_emit_found;
                    n_used      = r_emit_used;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_in_round     <= 1'b0;
            r_acc          <= '0;
            r_target       <= '0;
            r_sample_count <= SAMPLE_COUNT_RST;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_in_round     <= n_in_round;
            r_acc          <= n_acc;
            r_target       <= n_target;
            r_sample_count <= n_sample_count;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_emit_found <= n_emit_found;
        r_emit_idx   <= n_emit_idx;
        r_emit_used  <= n_emit_used;
        r_median     <= n_median;
        r_found      <= n_found;
        r_used       <= n_used;
    end

    `EMF_ASSERT_IMP(a_round_count_below_target, i_clk, i_rst_n, r_in_round, r_acc < r_target)
    `EMF_ASSERT_IMP(a_not_found_is_empty, i_clk, i_rst_n, o_out_valid && !o_found,
                    (o_median_time == '0) && (o_used_count == '0))
    `EMF_ASSERT_IMP(a_found_has_readings, i_clk, i_rst_n, o_out_valid && o_found,
                    o_used_count != '0)
    `EMF_ASSERT_NXT(a_emit_drains, i_clk, i_rst_n, (r_state == S_EMIT) && i_out_ready,
                    o_out_valid && (r_state == S_IDLE))

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Echo median filter core testbench
// Drives echo readings and sample count writes through valid/ready channels.
// A behavioral predictor builds the expected round results, and a checker
// compares every output transaction with them. Both sides idle at random,
// and the output side is held off for a long stretch to stall the input.
// ----------------------------------------------------------------------------
module tb;
    import emf_pkg::*;

    localparam int TW          = TIME_WIDTH_DEF;
    localparam int MAX_SAMPLES = MAX_SAMPLES_DEF;
    localparam int SETTLE      = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int NUM_PHASES  = 12;

    typedef struct packed {
        logic [TW-1:0]    median_time;
        logic             found;
        logic [CNT_W-1:0] used_count;
    } t_median;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [TW-1:0]    i_echo_time;
    logic             i_no_echo;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [TW-1:0]    o_median_time;
    logic             o_found;
    logic [CNT_W-1:0] o_used_count;

    // Predictor state.
    logic [CNT_W-1:0] count_setting;
    logic [TW-1:0]    sorted_times [MAX_SAMPLES];
    int               echoes_taken;
    int               round_goal;
    bit               round_open;

    t_median medians_due [$];
    int      mismatches;
    int      stall_cycles;
    bit      gaps_on;
    bit      hold_req;

    echo_median_filter_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_echo_time   (i_echo_time),
        .i_no_echo     (i_no_echo),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_median_time (o_median_time),
        .o_found       (o_found),
        .o_used_count  (o_used_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Inserts one reading into the descending store and reports whether the
    // round closes, either with a median or with no echo found at all.
    function automatic bit predict_median(input logic [TW-1:0] t, input logic missing,
                                          output t_median res);
        int j;
        res = '0;
        if (!round_open) begin
            if (count_setting == 0)
                round_goal = 1;
            else if (count_setting > MAX_SAMPLES)
                round_goal = MAX_SAMPLES;
            else
                round_goal = count_setting;
            echoes_taken = 0;
            round_open   = 1'b1;
        end
        if (missing) begin
            if (round_goal > 0)
                round_goal--;
        end else if (echoes_taken < round_goal) begin
            // Equal values land after the ones already stored.
            j = echoes_taken;
            while (j > 0 && sorted_times[j-1] < t) begin
                sorted_times[j] = sorted_times[j-1];
                j--;
            end
            sorted_times[j] = t;
            echoes_taken++;
        end
        if (round_goal == 0) begin
            round_open   = 1'b0;
            echoes_taken = 0;
            return 1'b1;
        end
        if (echoes_taken >= round_goal) begin
            res.median_time = sorted_times[round_goal >> 1];
            res.found       = 1'b1;
            res.used_count  = CNT_W'(echoes_taken);
            round_open      = 1'b0;
            echoes_taken    = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Predicts on every accepted input transaction and checks every output one.
    always @(posedge i_clk) begin
        t_median want;
        t_median got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                count_setting <= i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                if (predict_median(i_echo_time, i_no_echo, want))
                    medians_due.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_median_time, o_found, o_used_count};
                if (medians_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: median %0d found %0d used %0d",
                                 got.median_time, got.found, got.used_count);
                end else begin
                    want = medians_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected median %0d found %0d used %0d",
                                     want.median_time, want.found, want.used_count);
                            $display("          actual   median %0d found %0d used %0d",
                                     got.median_time, got.found, got.used_count);
                        end
                    end
                end
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Output side: random idling, or a long hold-off when one is requested.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= !(gaps_on && $urandom_range(99) < 21);
            end
        end
    end

    task automatic send_echo(input logic [TW-1:0] t, input logic missing);
        while (gaps_on && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_echo_time <= t;
        i_no_echo   <= missing;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stops offering readings until every pending result has come out.
    task automatic wait_for_medians();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (medians_due.size() != 0);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] v);
        wait_for_medians();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_echoes(input int n, input int miss_pct);
        logic [TW-1:0] t;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0:       t = '0;
                1:       t = '1;
                2, 3:    t = TW'($urandom_range(40, 32));
                default: t = TW'($urandom);
            endcase
            send_echo(t, $urandom_range(99) < miss_pct);
        end
    endtask

    // Reset count of five, with both time extremes, equal values and a miss
    // whose time field carries all ones and must be ignored.
    task automatic test_default_round();
        send_echo('0, 1'b0);
        send_echo('1, 1'b0);
        send_echo('1, 1'b1);
        send_echo(TW'(7), 1'b0);
        send_echo(TW'(7), 1'b0);
    endtask

    task automatic test_count_corners();
        // A count of zero acts as one, so a single miss ends in no echo found.
        write_count('0);
        send_echo(TW'(1234), 1'b1);
        // A write inside an open round only applies to the next round.
        write_count(CNT_W'(2));
        send_echo(TW'(500), 1'b0);
        write_count('1);
        send_echo(TW'(600), 1'b0);
        // All ones saturates to a full store.
        for (int k = 0; k < MAX_SAMPLES; k++)
            send_echo((k % 5 == 0) ? TW'(100) : TW'($urandom), 1'b0);
    endtask

    task automatic test_random_rounds();
        logic [CNT_W-1:0] corners [7] = '{1, 16, 31, 0, 5, 2, 17};
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_count((p < 7) ? corners[p] : CNT_W'($urandom_range(31)));
            send_random_echoes($urandom_range(55, 35), (p % 3 == 1) ? 55 : 12);
        end
    endtask

    task automatic test_steady_stream();
        gaps_on = 1'b0;
        write_count(CNT_W'(3));
        send_random_echoes(200, 10);
        gaps_on = 1'b1;
    endtask

    // Every echo closes a round, so the block fills while the output is held.
    task automatic test_output_backpressure();
        write_count(CNT_W'(1));
        hold_req = 1'b1;
        send_random_echoes(40, 0);
        wait_for_medians();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_echo_time   = '0;
        i_no_echo     = 1'b0;
        count_setting = SAMPLE_COUNT_RST;
        echoes_taken  = 0;
        round_goal    = 0;
        round_open    = 1'b0;
        mismatches    = 0;
        stall_cycles  = 0;
        gaps_on       = 1'b1;
        hold_req      = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_round();
        test_count_corners();
        test_random_rounds();
        test_steady_stream();
        test_output_backpressure();
        test_random_rounds();

        wait_for_medians();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && medians_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
